### hw/rtl/afd_pkg.sv
// shared types and constants for the arm instruction format decoder
package afd_pkg;

  // instruction format classes
  typedef enum logic [3:0] {
    ClsDataproc = 4'd0,
    ClsMrs      = 4'd1,
    ClsMsr      = 4'd2,
    ClsMul      = 4'd3,
    ClsMull     = 4'd4,
    ClsSwap     = 4'd5,
    ClsBx       = 4'd6,
    ClsHalf     = 4'd7,
    ClsSingle   = 4'd8,
    ClsBlock    = 4'd9,
    ClsBranch   = 4'd10,
    ClsSwi      = 4'd11,
    ClsCoproc   = 4'd12,
    ClsUndef    = 4'd13
  } fmt_class_e;

  // bits 27:4 of a branch and exchange
  localparam logic [23:0] BxPattern = 24'h12FFF1;

  // control bit masks per class
  localparam logic [6:0] CmaskMul      = 7'h03;
  localparam logic [6:0] CmaskMull     = 7'h07;
  localparam logic [6:0] CmaskSwap     = 7'h04;
  localparam logic [6:0] CmaskMrs      = 7'h04;
  localparam logic [6:0] CmaskMsr      = 7'h24;
  localparam logic [6:0] CmaskHalf     = 7'h1F;
  localparam logic [6:0] CmaskDpImm    = 7'h21;
  localparam logic [6:0] CmaskDpReg    = 7'h61;
  localparam logic [6:0] CmaskSingle   = 7'h3F;
  localparam logic [6:0] CmaskBlock    = 7'h1F;
  localparam logic [6:0] CmaskBranch   = 7'h10;

  // decoded fields of one instruction
  typedef struct packed {
    fmt_class_e  format_class;
    logic [3:0]  condition_code;
    logic [3:0]  operation_code;
    logic [3:0]  base_register;
    logic [3:0]  dest_register;
    logic [3:0]  rm_index;
    logic [3:0]  rs_index;
    logic [1:0]  shift_kind;
    logic [4:0]  shift_count;
    logic [6:0]  control_bits;
    logic [31:0] immediate_value;
  } afd_result_t;

endpackage

### hw/rtl/afd_decode.sv
// combinational field decode of one arm-state instruction word
module afd_decode (
  input  logic [31:0]          word_i,
  output afd_pkg::afd_result_t result_o
);

  logic [2:0]  top;
  logic [3:0]  opc;
  logic [6:0]  raw;
  logic [6:0]  cmask;
  logic [31:0] rot_imm;
  logic [63:0] rot_wide;
  logic [4:0]  rot_amt;

  // rotated 8-bit immediate, a zero rotation leaves the constant as it is
  always_comb begin
    rot_amt  = {word_i[11:8], 1'b0};
    rot_wide = {24'd0, word_i[7:0], 24'd0, word_i[7:0]} >> rot_amt;
    rot_imm  = rot_wide[31:0];
  end

  assign top = word_i[27:25];
  assign opc = word_i[24:21];
  assign raw = {word_i[4], word_i[25:20]};

  // class selection and field extraction
  always_comb begin
    result_o                = '0;
    result_o.format_class   = afd_pkg::ClsUndef;
    result_o.condition_code = word_i[31:28];
    cmask                   = '0;
    unique case (top)
      3'd0, 3'd1: begin
        if (top == 3'd0 && word_i[27:4] == afd_pkg::BxPattern) begin
          result_o.format_class = afd_pkg::ClsBx;
          result_o.rm_index     = word_i[3:0];
        end else if (top == 3'd0 && word_i[7] && word_i[4]) begin
          if (word_i[6:5] == 2'd0) begin
            // multiply and swap space
            if (word_i[24:22] == 3'b000) begin
              result_o.format_class  = afd_pkg::ClsMul;
              result_o.dest_register = word_i[19:16];
              result_o.base_register = word_i[15:12];
              result_o.rs_index      = word_i[11:8];
              result_o.rm_index      = word_i[3:0];
              cmask                  = afd_pkg::CmaskMul;
            end else if (word_i[24:23] == 2'b01) begin
              result_o.format_class  = afd_pkg::ClsMull;
              result_o.base_register = word_i[19:16];
              result_o.dest_register = word_i[15:12];
              result_o.rs_index      = word_i[11:8];
              result_o.rm_index      = word_i[3:0];
              cmask                  = afd_pkg::CmaskMull;
            end else if (word_i[24:23] == 2'b10 && word_i[21:20] == 2'b00) begin
              result_o.format_class  = afd_pkg::ClsSwap;
              result_o.base_register = word_i[19:16];
              result_o.dest_register = word_i[15:12];
              result_o.rm_index      = word_i[3:0];
              cmask                  = afd_pkg::CmaskSwap;
            end
          end else begin
            // halfword and signed transfers
            result_o.format_class   = afd_pkg::ClsHalf;
            result_o.operation_code = {2'b00, word_i[6:5]};
            result_o.base_register  = word_i[19:16];
            result_o.dest_register  = word_i[15:12];
            cmask                   = afd_pkg::CmaskHalf;
            if (word_i[22]) begin
              result_o.immediate_value = {24'd0, word_i[11:8], word_i[3:0]};
            end else begin
              result_o.rm_index = word_i[3:0];
            end
          end
        end else if (opc[3:2] == 2'b10 && !word_i[20]) begin
          // psr transfer space
          if (!word_i[21]) begin
            if (top == 3'd0) begin
              result_o.format_class  = afd_pkg::ClsMrs;
              result_o.dest_register = word_i[15:12];
              cmask                  = afd_pkg::CmaskMrs;
            end
          end else begin
            result_o.format_class  = afd_pkg::ClsMsr;
            result_o.base_register = word_i[19:16];
            cmask                  = afd_pkg::CmaskMsr;
            if (top == 3'd1) begin
              result_o.immediate_value = rot_imm;
            end else begin
              result_o.rm_index = word_i[3:0];
            end
          end
        end else begin
          // data processing
          result_o.format_class   = afd_pkg::ClsDataproc;
          result_o.operation_code = opc;
          result_o.base_register  = word_i[19:16];
          result_o.dest_register  = word_i[15:12];
          if (top == 3'd1) begin
            result_o.immediate_value = rot_imm;
            cmask                    = afd_pkg::CmaskDpImm;
          end else begin
            result_o.rm_index   = word_i[3:0];
            result_o.shift_kind = word_i[6:5];
            cmask               = afd_pkg::CmaskDpReg;
            if (word_i[4]) begin
              result_o.rs_index = word_i[11:8];
            end else begin
              result_o.shift_count = word_i[11:7];
            end
          end
        end
      end
      3'd2, 3'd3: begin
        // single data transfer, register form with bit 4 set is undefined
        if (!(top == 3'd3 && word_i[4])) begin
          result_o.format_class  = afd_pkg::ClsSingle;
          result_o.base_register = word_i[19:16];
          result_o.dest_register = word_i[15:12];
          cmask                  = afd_pkg::CmaskSingle;
          if (top == 3'd2) begin
            result_o.immediate_value = {20'd0, word_i[11:0]};
          end else begin
            result_o.rm_index    = word_i[3:0];
            result_o.shift_kind  = word_i[6:5];
            result_o.shift_count = word_i[11:7];
          end
        end
      end
      3'd4: begin
        result_o.format_class    = afd_pkg::ClsBlock;
        result_o.base_register   = word_i[19:16];
        cmask                    = afd_pkg::CmaskBlock;
        result_o.immediate_value = {16'd0, word_i[15:0]};
      end
      3'd5: begin
        result_o.format_class    = afd_pkg::ClsBranch;
        cmask                    = afd_pkg::CmaskBranch;
        result_o.immediate_value = {8'd0, word_i[23:0]};
      end
      3'd7: begin
        if (word_i[24]) begin
          result_o.format_class    = afd_pkg::ClsSwi;
          result_o.immediate_value = {8'd0, word_i[23:0]};
        end else begin
          result_o.format_class = afd_pkg::ClsCoproc;
        end
      end
      default: begin
        result_o.format_class = afd_pkg::ClsCoproc;
      end
    endcase
    result_o.control_bits = raw & cmask;
  end

endmodule

### hw/rtl/arm_instruction_format_decoder.sv
// arm-state instruction format decoder: input register, decode, result register
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------
//   in      | in_valid_i / in_ready_o  | instruction_word_i
//   out     | out_valid_o / out_ready_i| format_class_o .. immediate_value_o
//
// one transaction per cycle while the output is not stalled; a taken word is
// held in the input register, then decoded into the result register, which offers it.
// reset empties both register stages; no other state is kept.
// a stalled output holds its result while the input register still takes one
// more word; in_ready_o falls only when both stages are full and stalled.
module arm_instruction_format_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  format_class_o,
  output logic [3:0]  condition_code_o,
  output logic [3:0]  operation_code_o,
  output logic [3:0]  base_register_o,
  output logic [3:0]  dest_register_o,
  output logic [3:0]  rm_index_o,
  output logic [3:0]  rs_index_o,
  output logic [1:0]  shift_kind_o,
  output logic [4:0]  shift_count_o,
  output logic [6:0]  control_bits_o,
  output logic [31:0] immediate_value_o
);

  logic                 word_valid_q;
  logic [31:0]          word_q;
  logic                 res_valid_q;
  afd_pkg::afd_result_t res_q;
  afd_pkg::afd_result_t res_d;
  logic                 res_load;
  logic                 word_load;

  // stage hand-off
  assign res_load   = word_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !word_valid_q || res_load;
  assign word_load  = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      word_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_load) begin
      word_q <= instruction_word_i;
    end
  end

  // field decode
  afd_decode u_decode (
    .word_i   (word_q),
    .result_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // outputs
  assign out_valid_o       = res_valid_q;
  assign format_class_o    = res_q.format_class;
  assign condition_code_o  = res_q.condition_code;
  assign operation_code_o  = res_q.operation_code;
  assign base_register_o   = res_q.base_register;
  assign dest_register_o   = res_q.dest_register;
  assign rm_index_o        = res_q.rm_index;
  assign rs_index_o        = res_q.rs_index;
  assign shift_kind_o      = res_q.shift_kind;
  assign shift_count_o     = res_q.shift_count;
  assign control_bits_o    = res_q.control_bits;
  assign immediate_value_o = res_q.immediate_value;

  // an accepted word always lands in the input register
  a_word_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_load |=> word_valid_q)
    else $error("accepted word not held in input register");

  // a decoded word carries its own condition field to the result
  a_cond_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (out_valid_o && condition_code_o == $past(word_q[31:28])))
    else $error("condition field lost between stages");

  // a stalled result stays offered
  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("stalled result dropped");

  // classes with no control meaning report none
  a_ctrl_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (format_class_o == afd_pkg::ClsBx
                     || format_class_o == afd_pkg::ClsSwi
                     || format_class_o == afd_pkg::ClsCoproc
                     || format_class_o == afd_pkg::ClsUndef))
    |-> control_bits_o == 7'd0)
    else $error("control bits set for a class without them");

endmodule
